>>> src/yuyv_to_rgb565_converter_core_assert.svh
// Assertion macros shared by the converter's checker.
`ifndef YUYV_TO_RGB565_CONVERTER_CORE_ASSERT_SVH
`define YUYV_TO_RGB565_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define Y2R_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define Y2R_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/y2r_pkg.sv
// Shared types and constants of the YUYV to RGB565 converter.
package y2r_pkg;

  // Width of the in-frame pixel counter.
  localparam int COUNT_BITS = 22;
  // Width of the frame size register as written.
  localparam int CFG_BITS = 23;
  // Width that holds any usable frame size, up to and including 2^COUNT_BITS.
  localparam int FS_BITS = COUNT_BITS + 1;
  localparam int CMP_BITS = (CFG_BITS > FS_BITS) ? CFG_BITS : FS_BITS;

  localparam logic [CFG_BITS-1:0] FRAME_PIXELS_RESET = CFG_BITS'(307200);
  localparam logic [FS_BITS-1:0] FRAME_LIMIT = {1'b1, {COUNT_BITS{1'b0}}};

  // BT.601 full-range coefficients with 16 fraction bits.
  localparam int FRAC_BITS = 16;
  localparam logic [16:0] COEF_RV = 17'd91881;
  localparam logic [16:0] COEF_GU = 17'd22553;
  localparam logic [16:0] COEF_GV = 17'd46802;
  localparam logic [16:0] COEF_BU = 17'd116130;
  localparam logic [7:0] CHROMA_ZERO = 8'd128;

  // Widths of the signed chroma products and of the per-channel sums.
  localparam int PROD_BITS = 26;
  localparam int ACC_BITS  = 27;

  // Depth of the back end's result buffer; a power of two so the pointers wrap.
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } macropixel_t;

  typedef struct packed {
    logic [15:0] pixel_rgb565;
    logic        last_of_item;
    logic        end_of_frame;
  } pixel_t;

  // One classified macropixel: single is set when the first pixel closes the
  // frame, so the second is dropped; eof_second marks the second pixel as the
  // end of the frame.
  typedef struct packed {
    macropixel_t mp;
    logic        single;
    logic        eof_second;
  } job_t;

endpackage

>>> src/y2r_front.sv
// Front end: accepts macropixels, tracks the frame position and classifies each item.
module y2r_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  y2r_pkg::macropixel_t            macropixel,
  input  logic                            cfg_valid,
  input  logic [y2r_pkg::CFG_BITS-1:0]    cfg_data,
  output logic                            job_push,
  output y2r_pkg::job_t                   job,
  input  logic                            job_full
);

  // A size of zero means one pixel; anything above the counter range is capped.
  function automatic logic [y2r_pkg::FS_BITS-1:0] clamp_frame(
    input logic [y2r_pkg::CFG_BITS-1:0] value
  );
    logic [y2r_pkg::CMP_BITS-1:0] ext;
    logic [y2r_pkg::FS_BITS-1:0]  res;
    ext = y2r_pkg::CMP_BITS'(value);
    if (ext == '0) begin
      res = y2r_pkg::FS_BITS'(1);
    end else if (ext > y2r_pkg::CMP_BITS'(y2r_pkg::FRAME_LIMIT)) begin
      res = y2r_pkg::FRAME_LIMIT;
    end else begin
      res = y2r_pkg::FS_BITS'(ext);
    end
    return res;
  endfunction

  logic [y2r_pkg::FS_BITS-1:0]    frame_size;
  logic [y2r_pkg::COUNT_BITS-1:0] pixel_count;
  logic [y2r_pkg::COUNT_BITS-1:0] pixel_count_next;
  logic [y2r_pkg::FS_BITS-1:0]    first_pos;
  logic [y2r_pkg::FS_BITS-1:0]    second_pos;
  logic                           eof_first;
  logic                           eof_second;
  logic                           accept;

  assign full   = job_full;
  assign accept = push && !job_full;

  // Positions are one-based here, so reaching the frame size ends the frame.
  // A count already past a newly shrunk size ends the frame on the next pixel.
  assign first_pos  = {1'b0, pixel_count} + y2r_pkg::FS_BITS'(1);
  assign second_pos = first_pos + y2r_pkg::FS_BITS'(1);
  assign eof_first  = first_pos >= frame_size;
  assign eof_second = second_pos >= frame_size;

  always_comb begin
    if (eof_first || eof_second) begin
      pixel_count_next = '0;
    end else begin
      pixel_count_next = second_pos[y2r_pkg::COUNT_BITS-1:0];
    end
  end

  assign job_push        = accept;
  assign job.mp          = macropixel;
  assign job.single      = eof_first;
  assign job.eof_second  = eof_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size  <= clamp_frame(y2r_pkg::FRAME_PIXELS_RESET);
      pixel_count <= '0;
    end else begin
      if (cfg_valid) begin
        frame_size <= clamp_frame(cfg_data);
      end
      if (accept) begin
        pixel_count <= pixel_count_next;
      end
    end
  end

endmodule

>>> src/y2r_job_queue.sv
// Two-entry queue of classified macropixels between the front and back ends.
module y2r_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  y2r_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output logic          head_valid,
  output y2r_pkg::job_t head
);

  y2r_pkg::job_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_rd;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = entries[rd_ptr];
  assign do_rd      = rd_en && head_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr_en, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/y2r_back.sv
// Back end: converts one pixel a cycle in two stages while its result buffer has room, and buffers the results.
module y2r_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  y2r_pkg::job_t    head,
  output logic             head_pop,
  output logic             empty,
  input  logic             pop,
  output y2r_pkg::pixel_t  pixel
);

  function automatic logic [7:0] clamp_channel(
    input logic signed [y2r_pkg::ACC_BITS-1:0] acc
  );
    logic [7:0] res;
    if (acc[y2r_pkg::ACC_BITS-1]) begin
      res = 8'd0;
    end else if (acc[y2r_pkg::ACC_BITS-2:y2r_pkg::FRAC_BITS+8] != '0) begin
      res = 8'd255;
    end else begin
      res = acc[y2r_pkg::FRAC_BITS+7:y2r_pkg::FRAC_BITS];
    end
    return res;
  endfunction

  // Issue side.
  logic              half;
  logic              issue;
  logic              credit_ok;
  logic [7:0]        sel_luma;
  logic signed [7:0] u_val;
  logic signed [7:0] v_val;

  // First stage: the four products.
  logic                                 a_valid;
  logic [7:0]                           a_luma;
  logic signed [y2r_pkg::PROD_BITS-1:0] a_rv;
  logic signed [y2r_pkg::PROD_BITS-1:0] a_gu;
  logic signed [y2r_pkg::PROD_BITS-1:0] a_gv;
  logic signed [y2r_pkg::PROD_BITS-1:0] a_bu;
  logic                                 a_last;
  logic                                 a_eof;

  // Second stage: sums, clamping and packing.
  logic signed [y2r_pkg::ACC_BITS-1:0] base;
  logic signed [y2r_pkg::ACC_BITS-1:0] r_acc;
  logic signed [y2r_pkg::ACC_BITS-1:0] g_acc;
  logic signed [y2r_pkg::ACC_BITS-1:0] b_acc;
  logic [7:0]                          r_val;
  logic [7:0]                          g_val;
  logic [7:0]                          b_val;
  y2r_pkg::pixel_t                     result;

  // Result buffer.
  y2r_pkg::pixel_t                   out_buf [y2r_pkg::OUT_DEPTH];
  logic [y2r_pkg::OUT_PTR_BITS-1:0]  o_wr;
  logic [y2r_pkg::OUT_PTR_BITS-1:0]  o_rd;
  logic [y2r_pkg::OUT_CNT_BITS-1:0]  o_count;
  logic                              do_pop;

  // Room is reserved for the pixel still in the first stage.
  assign credit_ok = (o_count + y2r_pkg::OUT_CNT_BITS'(a_valid)) <
                     y2r_pkg::OUT_CNT_BITS'(y2r_pkg::OUT_DEPTH);
  assign issue     = head_valid && credit_ok;
  assign head_pop  = issue && (half || head.single);

  assign sel_luma = half ? head.mp.luma_second : head.mp.luma_first;
  assign u_val    = $signed(head.mp.chroma_blue - y2r_pkg::CHROMA_ZERO);
  assign v_val    = $signed(head.mp.chroma_red - y2r_pkg::CHROMA_ZERO);

  always_ff @(posedge clk) begin
    if (rst) begin
      half    <= 1'b0;
      a_valid <= 1'b0;
    end else begin
      a_valid <= issue;
      if (issue) begin
        half <= !half && !head.single;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_luma <= sel_luma;
      a_rv   <= $signed({1'b0, y2r_pkg::COEF_RV}) * v_val;
      a_gu   <= $signed({1'b0, y2r_pkg::COEF_GU}) * u_val;
      a_gv   <= $signed({1'b0, y2r_pkg::COEF_GV}) * v_val;
      a_bu   <= $signed({1'b0, y2r_pkg::COEF_BU}) * u_val;
      a_last <= half || head.single;
      a_eof  <= half ? head.eof_second : head.single;
    end
  end

  assign base  = $signed({{(y2r_pkg::ACC_BITS-8-y2r_pkg::FRAC_BITS){1'b0}}, a_luma,
                          {y2r_pkg::FRAC_BITS{1'b0}}});
  assign r_acc = base + y2r_pkg::ACC_BITS'(a_rv);
  assign g_acc = base - y2r_pkg::ACC_BITS'(a_gu) - y2r_pkg::ACC_BITS'(a_gv);
  assign b_acc = base + y2r_pkg::ACC_BITS'(a_bu);
  assign r_val = clamp_channel(r_acc);
  assign g_val = clamp_channel(g_acc);
  assign b_val = clamp_channel(b_acc);

  assign result.pixel_rgb565 = {r_val[7:3], g_val[7:2], b_val[7:3]};
  assign result.last_of_item = a_last;
  assign result.end_of_frame = a_eof;

  assign empty  = o_count == '0;
  assign pixel  = out_buf[o_rd];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (a_valid) begin
      out_buf[o_wr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= '0;
      o_rd    <= '0;
      o_count <= '0;
    end else begin
      if (a_valid) begin
        o_wr <= o_wr + y2r_pkg::OUT_PTR_BITS'(1);
      end
      if (do_pop) begin
        o_rd <= o_rd + y2r_pkg::OUT_PTR_BITS'(1);
      end
      case ({a_valid, do_pop})
        2'b10:   o_count <= o_count + y2r_pkg::OUT_CNT_BITS'(1);
        2'b01:   o_count <= o_count - y2r_pkg::OUT_CNT_BITS'(1);
        default: o_count <= o_count;
      endcase
    end
  end

endmodule

>>> src/yuyv_to_rgb565_converter_core.sv
// Top level of the YUYV 4:2:2 to RGB565 converter.
//
// The block takes one YUYV macropixel per item (two luma samples sharing one
// blue and one red chroma sample) and returns up to two RGB565 pixels, computed
// with full-range BT.601 coefficients with 16 fraction bits, truncated and
// clamped to 0..255 before packing. It counts pixels against the configured
// frame size; when a frame has an odd number of pixels the second pixel of
// the macropixel that closes it is dropped, and that single pixel carries both
// last_of_item and end_of_frame. A frame size of zero counts as one pixel, and
// sizes above the counter range are capped to it. Throughput is one pixel per
// cycle from the shared conversion pipeline while the result buffer has room,
// so the pixels of a macropixel pass it one after the other; new items are
// taken every cycle while the two-entry item queue has room. A pixel passes
// the item queue, the product registers and the result buffer on its way to
// the result ports. The frame size register may be written at any time the
// block holds no unfinished item; cfg_ready is always high.
module yuyv_to_rgb565_converter_core (
  input  logic                          clk,
  input  logic                          rst,
  // Item input, queue style.
  input  logic                          push,
  output logic                          full,
  input  y2r_pkg::macropixel_t          macropixel,
  // Result output, queue style.
  output logic                          empty,
  input  logic                          pop,
  output y2r_pkg::pixel_t               pixel,
  // Frame size register write.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [y2r_pkg::CFG_BITS-1:0]  cfg_data
);

  logic          job_push;
  logic          job_full;
  y2r_pkg::job_t job;
  logic          head_valid;
  logic          head_pop;
  y2r_pkg::job_t head;

  // The register is a plain flop, so a write is never held off.
  assign cfg_ready = 1'b1;

  // The front end decides per item whether one or two pixels follow and where
  // the frame ends, so the counter advances at acceptance and never waits on
  // the conversion.
  y2r_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .macropixel (macropixel),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .job_push   (job_push),
    .job        (job),
    .job_full   (job_full)
  );

  // The queue decouples acceptance from conversion, so a stalled result side
  // still lets a couple of items in.
  y2r_job_queue u_job_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (job_push),
    .wr_job     (job),
    .full       (job_full),
    .rd_en      (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back end converts one pixel per cycle while its four-entry result queue
  // has room, reserving room there for every pixel it has in flight.
  y2r_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .pixel      (pixel)
  );

endmodule

>>> src/y2r_checker.sv
// Port-level checker for the converter and its bind to the top level.
`include "yuyv_to_rgb565_converter_core_assert.svh"

module y2r_checker (
  input logic            clk,
  input logic            rst,
  input logic            full,
  input logic            push,
  input logic            empty,
  input logic            pop,
  input y2r_pkg::pixel_t pixel
);

  // The pixel that closes a frame is always the last one of its item.
  `Y2R_ASSERT_IMPLIES(a_eof_ends_item, !empty && pixel.end_of_frame, pixel.last_of_item, "frame ends mid item")

  // Both queues come out of reset empty.
  `Y2R_ASSERT_IMPLIES(a_reset_clears, $past(rst), empty && !full, "queues not empty after reset")

  // The input side fills up only through an accepted item.
  `Y2R_ASSERT_IMPLIES(a_full_by_push, $rose(full), $past(push && !full), "full raised without an item")

  // A waiting result stays put until it is taken.
  `Y2R_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(pixel), "waiting result changed")

endmodule

bind yuyv_to_rgb565_converter_core y2r_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .push  (push),
  .empty (empty),
  .pop   (pop),
  .pixel (pixel)
);

>>> test/yuyv_to_rgb565_converter_core_tb.sv
// Self-checking testbench for the YUYV 4:2:2 to RGB565 converter core.
`timescale 1ns / 100ps

module yuyv_to_rgb565_converter_core_tb;

  // Predicts the pixels of each accepted macropixel. It keeps its own frame size
  // and in-frame pixel position, and queues the pixels that have yet to arrive.
  class rgb565_pixel_model;
    localparam longint Q16_RED_V = 91881;
    localparam longint Q16_GREEN_U = 22553;
    localparam longint Q16_GREEN_V = 46802;
    localparam longint Q16_BLUE_U = 116130;
    localparam int unsigned MAX_FRAME = 32'd1 << 22;

    y2r_pkg::pixel_t pending_pixels[$];
    logic [22:0] frame_pixels;
    int unsigned pixel_position;
    int errors;

    function new();
      frame_pixels = 23'd307200;
      pixel_position = 0;
      errors = 0;
    endfunction

    function void set_frame_pixels(logic [22:0] value);
      frame_pixels = value;
    endfunction

    // A size of zero counts as one pixel; anything past the counter range is capped.
    function int unsigned frame_length();
      int unsigned n;
      n = 32'(frame_pixels);
      if (n == 0) n = 1;
      if (n > MAX_FRAME) n = MAX_FRAME;
      return n;
    endfunction

    // Moves on one pixel and reports whether that pixel closed the frame.
    function bit step_position();
      if (pixel_position + 1 >= frame_length()) begin
        pixel_position = 0;
        return 1'b1;
      end
      pixel_position = pixel_position + 1;
      return 1'b0;
    endfunction

    function int clamp_channel(longint acc);
      longint whole;
      if (acc < 0) return 0;
      whole = acc >>> 16;
      return (whole > 255) ? 255 : int'(whole);
    endfunction

    function logic [15:0] yuv_to_rgb565(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr);
      longint base;
      longint u;
      longint v;
      int r;
      int g;
      int b;
      base = longint'(luma) <<< 16;
      u = longint'(cb) - 128;
      v = longint'(cr) - 128;
      r = clamp_channel(base + Q16_RED_V * v);
      g = clamp_channel(base - Q16_GREEN_U * u - Q16_GREEN_V * v);
      b = clamp_channel(base + Q16_BLUE_U * u);
      return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function void note_macropixel(y2r_pkg::macropixel_t mp);
      y2r_pkg::pixel_t first;
      y2r_pkg::pixel_t second;
      first.pixel_rgb565 = yuv_to_rgb565(mp.luma_first, mp.chroma_blue, mp.chroma_red);
      if (step_position()) begin
        // The first pixel closes an odd frame, so the second one is dropped.
        first.last_of_item = 1'b1;
        first.end_of_frame = 1'b1;
        pending_pixels.push_back(first);
        return;
      end
      first.last_of_item = 1'b0;
      first.end_of_frame = 1'b0;
      pending_pixels.push_back(first);
      second.pixel_rgb565 = yuv_to_rgb565(mp.luma_second, mp.chroma_blue, mp.chroma_red);
      second.last_of_item = 1'b1;
      second.end_of_frame = step_position();
      pending_pixels.push_back(second);
    endfunction

    function void check_pixel(y2r_pkg::pixel_t got);
      y2r_pkg::pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("pixel %h arrived with nothing expected", got.pixel_rgb565);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_rgb565 !== want.pixel_rgb565) begin
        $error("pixel_rgb565: expected %h, got %h", want.pixel_rgb565, got.pixel_rgb565);
        errors++;
      end
      if (got.last_of_item !== want.last_of_item) begin
        $error("last_of_item: expected %b, got %b", want.last_of_item, got.last_of_item);
        errors++;
      end
      if (got.end_of_frame !== want.end_of_frame) begin
        $error("end_of_frame: expected %b, got %b", want.end_of_frame, got.end_of_frame);
        errors++;
      end
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // Frame size plan entries below zero are drawn at random when their phase starts.
  localparam int RANDOM_ODD_SIZE = -1;
  localparam int RANDOM_SMALL_SIZE = -2;
  localparam int NUM_PHASES = 13;
  localparam int FRAME_PLAN [NUM_PHASES] = '{
    5, 3, 0, 1, 8388607, 2, 4194304, 7, 4194303, 64,
    RANDOM_ODD_SIZE, RANDOM_SMALL_SIZE, 5
  };
  localparam int PHASE_ITEMS [NUM_PHASES] = '{
    60, 80, 60, 60, 150, 100, 150, 150, 100, 150, 150, 230, 100
  };
  localparam int NUM_DIRECTED = 12;
  localparam logic [31:0] DIRECTED_WORDS [NUM_DIRECTED] = '{
    32'h00000000, 32'hFFFFFFFF, 32'hFF00FF00, 32'h00FF00FF,
    32'h80808080, 32'h0000FFFF, 32'hFFFF0000, 32'hAA55AA55,
    32'h55AA55AA, 32'h00800080, 32'hFF80FF80, 32'h10EB80F0
  };
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  y2r_pkg::macropixel_t macropixel = '0;
  logic empty;
  logic pop = 1'b0;
  y2r_pkg::pixel_t pixel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [y2r_pkg::CFG_BITS-1:0] cfg_data = '0;

  rgb565_pixel_model converter_model = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  yuyv_to_rgb565_converter_core uut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .macropixel (macropixel),
    .empty      (empty),
    .pop        (pop),
    .pixel      (pixel),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side. Pop is decided at each falling edge: low throughout a long
  // hold-off when one has been requested (the count is kept here, so the sender
  // carries on pushing until the block fills and raises full), otherwise low at
  // random at the stall rate of the current phase.
  always @(negedge clk) begin
    if (rst) begin
      pop = 1'b0;
    end else if (hold_left > 0) begin
      pop = 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      pop = 1'b0;
    end else begin
      pop = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every pixel taken at a rising edge is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && pop && !empty) converter_model.check_pixel(pixel);
  end

  // Watchdog: any cycle with no handshake at all counts towards the limit.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("yuyv_to_rgb565_converter_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one macropixel, idling first at random at the sender rate of the
  // current phase, and hands it to the model once the block has taken it.
  // Called and left at a falling edge; push stays high between items sent back
  // to back.
  task automatic send_macropixel(input y2r_pkg::macropixel_t mp);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    macropixel = mp;
    do @(posedge clk); while (full);
    converter_model.note_macropixel(mp);
    @(negedge clk);
  endtask

  // Writes the frame size register; called and left at a falling edge.
  task automatic write_frame_pixels(input logic [y2r_pkg::CFG_BITS-1:0] value);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    converter_model.set_frame_pixels(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Waits until every predicted pixel has come out, then lets the pipeline settle.
  task automatic wait_for_drain();
    push = 1'b0;
    while (converter_model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Bytes lean towards the extremes so that the clamps at 0 and 255 are hit often.
  function automatic logic [7:0] random_sample();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic y2r_pkg::macropixel_t random_macropixel();
    y2r_pkg::macropixel_t mp;
    mp.luma_first = random_sample();
    mp.chroma_blue = random_sample();
    mp.luma_second = random_sample();
    mp.chroma_red = random_sample();
    return mp;
  endfunction

  function automatic void set_idle_mode(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 53;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 53;
      end
      default: begin
        send_idle_pct = 13;
        recv_stall_pct = 13;
      end
    endcase
  endfunction

  initial begin
    int frame_size;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed items at the reset frame size: black, white, saturated and
    // alternating bit patterns, all at full rate.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_macropixel(y2r_pkg::macropixel_t'(DIRECTED_WORDS[i]));
    end

    // Each phase changes the frame size while the block is idle. The first write
    // shrinks the frame below the position already reached, the odd sizes drop
    // a second pixel at each frame end, and zero and the oversized values
    // exercise the size limits.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_drain();
      frame_size = FRAME_PLAN[p];
      if (frame_size == RANDOM_ODD_SIZE) frame_size = 2 * $urandom_range(1, 20) + 1;
      if (frame_size == RANDOM_SMALL_SIZE) frame_size = $urandom_range(1, 300);
      write_frame_pixels(y2r_pkg::CFG_BITS'(frame_size));
      set_idle_mode(idle_mode_e'(p % 4));
      if (p == 4 || p == 9) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        send_macropixel(random_macropixel());
      end
    end

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (converter_model.errors == 0) begin
      $display("yuyv_to_rgb565_converter_core regression: pass");
    end else begin
      $display("yuyv_to_rgb565_converter_core regression: fail");
    end
    $finish;
  end

endmodule
